// ----- src/otc_pkg.sv -----
`default_nettype none
package otc_pkg;

   localparam int TRIM_BITS  = 8;
   localparam int COUNT_BITS = 21;

   // item kinds
   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_MEASURE = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [TRIM_BITS-1:0]  initial_trim;
      logic [COUNT_BITS-1:0] measured_count;
   } otc_req_type;

   typedef struct packed {
      logic [TRIM_BITS-1:0] trim_code;
      logic                 write_trim;
      logic                 done_res;
      logic                 measure_again;
   } otc_rsp_type;

   typedef struct packed {
      logic                  finished;
      logic                  was_below;
      logic                  was_above;
      logic [TRIM_BITS-1:0]  current_trim;
      logic [TRIM_BITS-1:0]  previous_trim;
      logic [COUNT_BITS-1:0] previous_count;
   } otc_state_type;

endpackage
`default_nettype wire

// ----- src/otc_step.sv -----
`default_nettype none
module otc_step
   import otc_pkg::*;
(
   input  wire otc_req_type             item,
   input  wire otc_state_type           state_cur,
   input  wire logic [COUNT_BITS-1:0]   ideal_count,
   output otc_state_type                state_nxt,
   output otc_rsp_type                  result
);

   logic                         below;
   logic                         above;
   logic signed [COUNT_BITS:0]   dist_now_lo;   // ideal - count
   logic signed [COUNT_BITS:0]   dist_now_hi;   // count - ideal
   logic signed [COUNT_BITS:0]   dist_prev_hi;  // previous - ideal
   logic signed [COUNT_BITS:0]   dist_prev_lo;  // ideal - previous
   logic                         write;

   assign below = item.measured_count < ideal_count;
   assign above = item.measured_count > ideal_count;
   assign dist_now_lo  = $signed({1'b0, ideal_count}) - $signed({1'b0, item.measured_count});
   assign dist_now_hi  = $signed({1'b0, item.measured_count}) - $signed({1'b0, ideal_count});
   assign dist_prev_hi = $signed({1'b0, state_cur.previous_count}) - $signed({1'b0, ideal_count});
   assign dist_prev_lo = $signed({1'b0, ideal_count}) - $signed({1'b0, state_cur.previous_count});

   always_comb begin
      state_nxt = state_cur;
      write     = 1'b0;
      case (item.mode)
         MODE_START: begin
            state_nxt.finished     = 1'b0;
            state_nxt.was_below    = 1'b0;
            state_nxt.was_above    = 1'b0;
            state_nxt.current_trim = item.initial_trim;
         end
         MODE_MEASURE: begin
            if (below) begin
               if (state_cur.was_above) begin
                  // crossed from above: keep the closer trim
                  if (dist_now_lo > dist_prev_hi) begin
                     state_nxt.current_trim = state_cur.previous_trim;
                  end
                  state_nxt.finished = 1'b1;
               end else if (dist_now_lo == (COUNT_BITS+1)'(1)) begin
                  state_nxt.finished = 1'b1;
               end else begin
                  state_nxt.previous_trim = state_cur.current_trim;
                  if (state_cur.current_trim != '1) begin
                     state_nxt.current_trim = state_cur.current_trim + TRIM_BITS'(1);
                  end
                  state_nxt.was_below      = 1'b1;
                  state_nxt.previous_count = item.measured_count;
               end
            end else if (above) begin
               if (state_cur.was_below) begin
                  // crossed from below: keep the closer trim
                  if (dist_now_hi > dist_prev_lo) begin
                     state_nxt.current_trim = state_cur.previous_trim;
                  end
                  state_nxt.finished = 1'b1;
               end else if (dist_now_hi == (COUNT_BITS+1)'(1)) begin
                  state_nxt.finished = 1'b1;
               end else begin
                  state_nxt.previous_trim = state_cur.current_trim;
                  if (state_cur.current_trim != '0) begin
                     state_nxt.current_trim = state_cur.current_trim - TRIM_BITS'(1);
                  end
                  state_nxt.was_above      = 1'b1;
                  state_nxt.previous_count = item.measured_count;
               end
            end
            if (!below && !above) begin
               state_nxt.finished = 1'b1;
            end else begin
               write = 1'b1;
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

   assign result.trim_code     = state_nxt.current_trim;
   assign result.write_trim    = write;
   assign result.done_res      = state_nxt.finished;
   assign result.measure_again = !state_nxt.finished;

endmodule
`default_nettype wire

// ----- src/oscillator_trim_calibrator.sv -----
`default_nettype none
// oscillator trim calibrator
//
// req channel: one item is either a start (mode 0, carries the trim now in
// the oscillator) or a measurement (mode 1, carries the finished count).
// rsp channel: exactly one item per request with the trim to use, whether
// to write it, the done flag and whether to measure again.
// csr port: csr_write_enable/csr_write_data load the ideal count; write it
// only while no items are in flight.
//
// an accepted item is loaded into the input register; the compare-and-step
// logic then loads its result into the result register, which drives
// rsp_valid. throughput is one item per cycle while rsp_stall is low; the
// only loop is the trim state update through state_ff.
// reset clears the calibration state, the ideal count and both valid bits.
// when rsp_stall is high the result holds; the input register keeps one
// more item and req_stall rises only once both stages are full.
module oscillator_trim_calibrator
   import otc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [COUNT_BITS-1:0] csr_write_data,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_mode,
   input  wire logic [TRIM_BITS-1:0]  req_initial_trim,
   input  wire logic [COUNT_BITS-1:0] req_measured_count,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [TRIM_BITS-1:0]  rsp_trim_code,
   output      logic                  rsp_write_trim,
   output      logic                  rsp_done_res,
   output      logic                  rsp_measure_again
);

   // configuration
   logic [COUNT_BITS-1:0] ideal_ff;

   // input register
   logic        in_valid_ff;
   otc_req_type in_item_ff;

   // calibration state
   otc_state_type state_ff;
   otc_state_type state_in;

   // result register
   logic        out_valid_ff;
   otc_rsp_type out_item_ff;
   otc_rsp_type step_rsp;

   logic out_free;
   logic step_fire;
   logic req_take;

   // result register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   // input register can load when empty or moving on this cycle
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   otc_step u_step (
      .item        (in_item_ff),
      .state_cur   (state_ff),
      .ideal_count (ideal_ff),
      .state_nxt   (state_in),
      .result      (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ideal_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            ideal_ff <= csr_write_data;
         end
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step_fire) begin
            in_valid_ff <= 1'b0;
         end
         if (step_fire) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.mode           <= req_mode;
         in_item_ff.initial_trim   <= req_initial_trim;
         in_item_ff.measured_count <= req_measured_count;
      end
      if (step_fire) begin
         out_item_ff <= step_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trim_code     = out_item_ff.trim_code;
   assign rsp_write_trim    = out_item_ff.write_trim;
   assign rsp_done_res      = out_item_ff.done_res;
   assign rsp_measure_again = out_item_ff.measure_again;

`ifndef NO_ASSERTIONS
   // a start item always reports tuning in progress and no trim write
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_item_ff.mode == MODE_START |=>
         rsp_valid && !rsp_write_trim && !rsp_done_res)
      else $error("start item gave a write or done result");

   // an exact match finishes tuning without a write
   a_exact_match: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_item_ff.mode == MODE_MEASURE
         && in_item_ff.measured_count == ideal_ff |=>
         rsp_done_res && !rsp_write_trim)
      else $error("exact match did not finish tuning");

   // done and measure-again are complementary on every result
   a_done_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res != rsp_measure_again)
      else $error("done and measure-again disagree");

   // back pressure only when the input register really holds an item and the result register is full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("req_stall raised with a free stage");
`endif

endmodule
`default_nettype wire
